>>> design/assert_macros.svh
// Assertion macros shared by the design files.
// Depends on nothing; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/vts_pkg.sv
// Types and constants of the version tag scanner.
// Depends on nothing; imported by version_tag_scanner_core and the bench.
package vts_pkg;

   localparam int TAG_LEN = 9;
   localparam int RB_DEPTH = TAG_LEN - 1;
   localparam int SIZE_W = 21;
   localparam int OFS_W = 20;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 21'd65536;

   // Tag "$AppInfo$"
   localparam logic [7:0] TAG_BYTES [TAG_LEN] = '{
      8'h24, 8'h41, 8'h70, 8'h70, 8'h49, 8'h6E, 8'h66, 8'h6F, 8'h24
   };

   typedef enum logic [2:0] {
      PH_SEARCH = 3'b001,
      PH_WINDOW = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   typedef struct packed {
      logic             found;
      logic [OFS_W-1:0] string_offset;
   } rsp_type;

endpackage

>>> design/version_tag_scanner_core.sv
// Version tag scanner: streams image bytes and reports the version string offset.
// Depends on vts_pkg and assert_macros.svh.
//
//   channel  | direction | handshake       | payload
//   req_     | in        | valid / ready   | data, first
//   rsp_     | out       | valid / ready   | found, string_offset
//   csr_     | in        | write enable    | write data (image_size)
//
// One byte is taken every cycle while req_ready is high; the scan state updates in the accepting cycle.
// A result is registered in the output register, or in the skid while that one is full, and drives rsp_.
// Two result slots (output register plus skid) keep req_ready high unless both hold.
// Reset (synchronous) starts a fresh scan and sets image_size to 65536.
`include "assert_macros.svh"

module version_tag_scanner_core
   import vts_pkg::*;
#(
   parameter int MAX_IMAGE_BYTES  = 1048576,
   parameter int MAX_STRING_BYTES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data,
   input  logic              req_first,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [OFS_W-1:0]  rsp_string_offset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_IMAGE_BYTES + 1);
   localparam int CMP_W = ((IDX_W > SIZE_W) ? IDX_W : SIZE_W) + 1;
   localparam int WC_W  = $clog2(MAX_STRING_BYTES + 1);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_IMAGE_BYTES);
   localparam logic [CMP_W-1:0] SIZE_MAX = CMP_W'(MAX_IMAGE_BYTES);
   // Tag start p counts if p + margin < size; with p = idx - 8 this is idx + gap < size
   localparam logic [CMP_W-1:0] END_GAP = CMP_W'(MAX_STRING_BYTES + 10 - RB_DEPTH);
   localparam logic [WC_W-1:0]  WC_LIMIT = WC_W'(MAX_STRING_BYTES);

   logic [SIZE_W-1:0] image_size_ff;
   logic [7:0]        recent_ff [RB_DEPTH];
   logic [7:0]        recent_in [RB_DEPTH];
   logic [IDX_W-1:0]  byte_index_ff, byte_index_in;
   phase_type         phase_ff, phase_in;
   logic [WC_W-1:0]   window_count_ff, window_count_in;
   logic [OFS_W-1:0]  match_offset_ff, match_offset_in;

   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_type           skid_ff, skid_in;

   logic              accept;
   logic              pop;
   logic              res_valid;
   rsp_type           res;

   // Effective state after an optional restart
   logic [7:0]        rb_cur [RB_DEPTH];
   logic [IDX_W-1:0]  idx_cur;
   phase_type         phase_cur;
   logic [WC_W-1:0]   wc_cur, wc_inc;
   logic [OFS_W-1:0]  mo_cur;
   logic [CMP_W-1:0]  img_ext, size_eff, idx_ext;
   logic              tag_hit;

   assign accept = req_valid && req_ready;
   assign pop    = out_valid_ff && rsp_ready;

   // Hold the image size register
   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         image_size_ff <= csr_wr_data;
      end
   end

   // Scan step for one item
   always_comb begin
      for (int i = 0; i < RB_DEPTH; i++) begin
         rb_cur[i] = req_first ? 8'd0 : recent_ff[i];
      end
      idx_cur   = req_first ? '0 : byte_index_ff;
      phase_cur = req_first ? PH_SEARCH : phase_ff;
      wc_cur    = req_first ? '0 : window_count_ff;
      mo_cur    = req_first ? '0 : match_offset_ff;
      wc_inc    = wc_cur + 1'b1;

      img_ext  = CMP_W'(image_size_ff);
      size_eff = (img_ext > SIZE_MAX) ? SIZE_MAX : img_ext;
      idx_ext  = CMP_W'(idx_cur);

      tag_hit = (idx_cur >= IDX_W'(RB_DEPTH)) && (req_data == TAG_BYTES[TAG_LEN-1]);
      for (int i = 0; i < RB_DEPTH; i++) begin
         if (rb_cur[i] != TAG_BYTES[i]) begin
            tag_hit = 1'b0;
         end
      end

      phase_in        = phase_cur;
      window_count_in = wc_cur;
      match_offset_in = mo_cur;
      res_valid       = 1'b0;
      res.found         = 1'b0;
      res.string_offset = '0;

      unique case (phase_cur)
         PH_SEARCH: begin
            if (tag_hit && ((idx_ext + END_GAP) < size_eff)) begin
               phase_in        = PH_WINDOW;
               match_offset_in = OFS_W'(idx_ext + 1'b1);
               window_count_in = '0;
            end else if ((idx_ext + 1'b1) >= size_eff) begin
               phase_in  = PH_DONE;
               res_valid = 1'b1;
            end
         end
         PH_WINDOW: begin
            if (req_data == 8'd0) begin
               phase_in          = PH_DONE;
               res_valid         = 1'b1;
               res.found         = 1'b1;
               res.string_offset = mo_cur;
            end else begin
               window_count_in = wc_inc;
               if (wc_inc >= WC_LIMIT) begin
                  phase_in  = PH_DONE;
                  res_valid = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      // Shift the byte history and advance the offset
      for (int i = 0; i < RB_DEPTH - 1; i++) begin
         recent_in[i] = rb_cur[i+1];
      end
      recent_in[RB_DEPTH-1] = req_data;
      byte_index_in = (idx_cur == IDX_MAX) ? idx_cur : idx_cur + 1'b1;

      res_valid = res_valid && accept;
   end

   // Hold scan state; advance on each item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RB_DEPTH; i++) begin
            recent_ff[i] <= 8'd0;
         end
         byte_index_ff   <= '0;
         phase_ff        <= PH_SEARCH;
         window_count_ff <= '0;
         match_offset_ff <= '0;
      end else if (accept) begin
         recent_ff       <= recent_in;
         byte_index_ff   <= byte_index_in;
         phase_ff        <= phase_in;
         window_count_ff <= window_count_in;
         match_offset_ff <= match_offset_in;
      end
   end

   // Result slots: output register fed from skid first, then from the scan
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Drop payload into the slots without reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_ready         = !skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = out_ff.found;
   assign rsp_string_offset = out_ff.string_offset;

   `ASSERT_ALWAYS(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff)
   `ASSERT_IMPLY(a_miss_zero_ofs, clock, reset, rsp_valid && !rsp_found, rsp_string_offset == '0)
   `ASSERT_IMPLY(a_window_bound, clock, reset, phase_ff == PH_WINDOW, window_count_ff < WC_LIMIT)
   `ASSERT_ALWAYS(a_index_bound, clock, reset, byte_index_ff <= IDX_MAX)

endmodule

>>> bench/version_scan_checker.sv
// Checker for the version tag scanner: watches the byte, result and register ports.
// Predicts one verdict per scanned image and compares it with the block's result.
// Depends on vts_pkg for the result and phase types, the widths and the reset size.
module version_scan_checker
   import vts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [7:0]        req_data,
   input  logic              req_first,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_found,
   input  logic [OFS_W-1:0]  rsp_string_offset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   output int                pending,
   output int                fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IMG_CAP   = 1048576;
   localparam int unsigned WIN_BYTES = 128;
   localparam int unsigned TAG_ROOM  = 138;
   localparam logic [71:0] APP_TAG   = "$AppInfo$";

   // Scan state of the predicted block
   logic [7:0]        last_bytes [8];
   logic [SIZE_W-1:0] ofs_count;
   phase_type         scan_phase;
   logic [7:0]        win_count;
   logic [SIZE_W-1:0] str_ofs;
   logic [SIZE_W-1:0] size_reg;

   rsp_type verdict_q [$];
   int      mismatch_total;

   // Clear the scan back to offset 0
   function automatic void restart_scan();
      for (int i = 0; i < 8; i++) last_bytes[i] = 8'h00;
      ofs_count  = '0;
      scan_phase = PH_SEARCH;
      win_count  = 8'd0;
      str_ofs    = '0;
   endfunction

   // Advance the scan by one byte; raise has_rsp when the byte ends the scan
   function automatic void scan_byte(input logic [7:0] d, input logic f,
                                     output logic has_rsp, output rsp_type verdict);
      int unsigned lim;
      int unsigned pos;
      logic        tag_seen;
      has_rsp = 1'b0;
      verdict = '0;
      if (f) restart_scan();
      lim = (size_reg > IMG_CAP) ? IMG_CAP : size_reg;
      pos = 32'(ofs_count);
      case (scan_phase)
         PH_SEARCH: begin
            tag_seen = (pos >= 8) && (d == APP_TAG[7:0]);
            for (int i = 0; i < 8; i++) begin
               if (last_bytes[i] != APP_TAG[71-8*i -: 8]) tag_seen = 1'b0;
            end
            if (tag_seen && (pos - 8 + TAG_ROOM < lim)) begin
               scan_phase = PH_WINDOW;
               str_ofs    = SIZE_W'(pos + 1);
               win_count  = 8'd0;
            end else if (pos + 1 >= lim) begin
               has_rsp    = 1'b1;
               scan_phase = PH_DONE;
            end
         end
         PH_WINDOW: begin
            if (d == 8'h00) begin
               has_rsp               = 1'b1;
               verdict.found         = 1'b1;
               verdict.string_offset = str_ofs[OFS_W-1:0];
               scan_phase            = PH_DONE;
            end else begin
               win_count = win_count + 8'd1;
               if (win_count >= WIN_BYTES) begin
                  has_rsp    = 1'b1;
                  scan_phase = PH_DONE;
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < 7; i++) last_bytes[i] = last_bytes[i+1];
      last_bytes[7] = d;
      if (ofs_count < IMG_CAP) ofs_count = ofs_count + 1'b1;
   endfunction

   // Count a failure and report the first few
   task automatic log_fail(input string msg);
      mismatch_total++;
      if (mismatch_total <= 10) $display("[%0t] %s", $realtime, msg);
   endtask

   // Compare results first, then predict the accepted byte, then apply a register write
   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      rsp_type pred;
      logic    has_rsp;
      if (reset) begin
         restart_scan();
         size_reg = SIZE_RESET;
         verdict_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.found         = rsp_found;
            got.string_offset = rsp_string_offset;
            if (verdict_q.size() == 0) begin
               log_fail($sformatf("unexpected result: found=%0d offset=%0d",
                                  got.found, got.string_offset));
            end else begin
               want = verdict_q.pop_front();
               if (got.found !== want.found || got.string_offset !== want.string_offset)
                  log_fail($sformatf("expected found=%0d offset=%0d, got found=%0d offset=%0d",
                                     want.found, want.string_offset,
                                     got.found, got.string_offset));
            end
         end
         if (req_valid && req_ready) begin
            scan_byte(req_data, req_first, has_rsp, pred);
            if (has_rsp) verdict_q.push_back(pred);
         end
         if (csr_wr_en) size_reg = csr_wr_data;
      end
      pending    <= verdict_q.size();
      fail_count <= mismatch_total;
   end

endmodule

>>> bench/testbench.sv
// Top of the version tag scanner bench: clock, reset, image streams and register writes.
// Depends on vts_pkg, version_tag_scanner_core and version_scan_checker.
module testbench
   import vts_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {IMG_FOUND, IMG_OPEN, IMG_MISS, IMG_CUT} image_kind_type;

   localparam int unsigned IMG_CAP = 1048576;
   localparam int unsigned EDGE_SIZES [5] = '{148, 0, 1, 1048576, 2097151};

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [7:0]        req_data;
   logic              req_first;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_found;
   logic [OFS_W-1:0]  rsp_string_offset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;

   int pending;
   int fail_count;
   int items_sent = 0;
   bit req_calm = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   version_tag_scanner_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .req_first         (req_first),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_string_offset (rsp_string_offset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   version_scan_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .req_first         (req_first),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_string_offset (rsp_string_offset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .pending           (pending),
      .fail_count        (fail_count)
   );

   // Pick the idle time before the next item: mostly none, some short, a few long
   function automatic int unsigned req_gap();
      int unsigned r;
      if (req_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one item and hold it until accepted
   task automatic put_byte(input logic [7:0] d, input logic f, input bit counted);
      int unsigned gap;
      gap = req_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      req_first <= f;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (counted) items_sent++;
   endtask

   task automatic put_tag(input logic f);
      put_byte(TAG_BYTES[0], f, 1'b1);
      for (int i = 1; i < TAG_LEN; i++) put_byte(TAG_BYTES[i], 1'b0, 1'b1);
   endtask

   // Drop valid and wait until every predicted result has come out
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_image_size(input logic [SIZE_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic int unsigned pick_size();
      case ($urandom_range(0, 19))
         0:       return 148;
         1:       return 149;
         2:       return $urandom_range(0, 147);
         3:       return IMG_CAP;
         4:       return $urandom_range(IMG_CAP + 1, 2097151);
         5:       return 65536;
         6:       return $urandom_range(1001, IMG_CAP - 1);
         default: return $urandom_range(150, 600);
      endcase
   endfunction

   // Full-length images only where the size keeps them short
   function automatic image_kind_type pick_kind(input int unsigned lim);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (lim < 148) return IMG_MISS;
      if (lim > 1000) begin
         if (r < 60) return IMG_FOUND;
         if (r < 85) return IMG_OPEN;
         return IMG_CUT;
      end
      if (r < 45) return IMG_FOUND;
      if (r < 60) return IMG_OPEN;
      if (r < 85) return IMG_MISS;
      return IMG_CUT;
   endfunction

   // Stream one image of the given kind, then, unless cut short, a few bytes the block should ignore
   task automatic send_image(input image_kind_type kind, input int unsigned lim);
      int unsigned p;
      int unsigned span;
      int unsigned len;
      int unsigned total;
      int unsigned late;
      int unsigned near;
      int unsigned n;
      logic        f;
      f = 1'b1;
      case (kind)
         IMG_FOUND, IMG_OPEN: begin
            // place the tag early, or at the last offset that still counts
            span = lim - 139;
            if (lim <= 2000 && $urandom_range(0, 4) == 0) p = span;
            else p = $urandom_range(0, (span < 60) ? span : 60);
            repeat (p) begin
               put_byte(8'($urandom_range(0, 255)), f, 1'b1);
               f = 1'b0;
            end
            put_tag(f);
            if (kind == IMG_FOUND) begin
               len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 12);
               repeat (len) put_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
               put_byte(8'h00, 1'b0, 1'b1);
            end else begin
               repeat (128) put_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
            end
         end
         IMG_MISS: begin
            // noise, a broken tag, and a tag that starts one byte too late
            total = (lim == 0) ? 1 : lim;
            late  = (lim >= 147 && $urandom_range(0, 1) == 1) ? lim - 138 : total;
            near  = (lim >= 160) ? $urandom_range(0, lim - 160) : total;
            n = 0;
            while (n < total) begin
               if (n == late) begin
                  put_tag(f);
                  n += TAG_LEN;
               end else if (n == near) begin
                  for (int i = 0; i < TAG_LEN - 1; i++) begin
                     put_byte(TAG_BYTES[i], (i == 0) && f, 1'b1);
                  end
                  put_byte(8'h25, 1'b0, 1'b1);
                  n += TAG_LEN;
               end else begin
                  put_byte(8'($urandom_range(0, 255)), f, 1'b1);
                  n++;
               end
               f = 1'b0;
            end
         end
         default: begin
            // stop short of the image end, possibly inside the string window
            if ($urandom_range(0, 1) == 1) begin
               put_tag(f);
               repeat ($urandom_range(0, 30)) put_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
            end else begin
               repeat ($urandom_range(1, 40)) begin
                  put_byte(8'($urandom_range(0, 255)), f, 1'b1);
                  f = 1'b0;
               end
            end
         end
      endcase
      if (kind != IMG_CUT)
         repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
   endtask

   // Result side: stretches of steady ready, short stalls, or rare long stalls
   initial begin : rsp_side
      int unsigned mode;
      rsp_ready = 1'b1;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(20, 200)) begin
            @(negedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: begin
                  if ($urandom_range(0, 29) == 0) begin
                     rsp_ready <= 1'b0;
                     repeat ($urandom_range(10, 60)) @(negedge clock);
                  end
                  rsp_ready <= 1'b1;
               end
            endcase
         end
      end
   end

   initial begin : stimulus
      int unsigned size_val;
      int unsigned lim;
      int unsigned phase_no;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = 8'h00;
      req_first   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // first image without a first flag, tag at offset 0, empty string
      req_calm = 1'b1;
      put_tag(1'b0);
      put_byte(8'h00, 1'b0, 1'b1);
      // restart with first, tag at offset 0, short string of extreme bytes
      put_tag(1'b1);
      put_byte(8'hFF, 1'b0, 1'b1);
      put_byte(8'h80, 1'b0, 1'b1);
      put_byte(8'h01, 1'b0, 1'b1);
      put_byte(8'h00, 1'b0, 1'b1);

      // edge sizes first, then random sizes until enough items
      phase_no = 0;
      while (phase_no < 5 || items_sent < 1300) begin
         size_val = (phase_no < 5) ? EDGE_SIZES[phase_no] : pick_size();
         set_image_size(size_val[SIZE_W-1:0]);
         lim = (size_val > IMG_CAP) ? IMG_CAP : size_val;
         repeat ($urandom_range(4, 8)) begin
            if (phase_no >= 5 && items_sent >= 1300) break;
            req_calm = ($urandom_range(0, 9) < 3);
            send_image(pick_kind(lim), lim);
         end
         phase_no++;
      end

      drain();
      if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> version_tag_scanner_core.f
+incdir+design
design/vts_pkg.sv
design/version_tag_scanner_core.sv
bench/version_scan_checker.sv
bench/testbench.sv
